// ----- sv/rmq_pkg.sv -----
// Shared types and constants for the rotation-matrix-to-quaternion unit.
package rmq_pkg;

  localparam int ELEM_W    = 16;
  localparam int NUM_ELEM  = 9;
  localparam int T_W       = 17;
  localparam int MAG_W     = 17;
  localparam int SQ_W      = 33;
  localparam int RAD_W     = 34;
  localparam int ROOT_W    = 17;
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int SQRT_LAT  = ROOT_W;
  localparam int SIDE_LAT  = DIV_LAT + SQRT_LAT;
  localparam int ONE_Q14   = 16384;

  typedef enum logic [1:0] {
    PATH_TRACE = 2'd0,
    PATH_R00   = 2'd1,
    PATH_R11   = 2'd2,
    PATH_R22   = 2'd3
  } rmq_path_t;

  // Classified item: t value, path, and magnitude/sign of the three pair terms
  // (A = r01/r10, B = r20/r02, C = r12/r21).
  typedef struct packed {
    logic [T_W-1:0]   t;
    rmq_path_t        path;
    logic [2:0]       neg;
    logic [MAG_W-1:0] mag_a;
    logic [MAG_W-1:0] mag_b;
    logic [MAG_W-1:0] mag_c;
  } rmq_item_t;

endpackage

// ----- sv/rmq_front.sv -----
// Input stage: accepts a matrix, picks the path and forms t and the pair terms.
module rmq_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [143:0]          in_data,
  input  logic                  q_full,
  output logic                  q_push,
  output rmq_pkg::rmq_item_t    q_item
);
  import rmq_pkg::*;

  logic signed [ELEM_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [17:0]       diag_sum;
  logic signed [18:0]       t_full;
  rmq_path_t                path_sel;
  logic signed [17:0]       d_a, d_b, d_c;
  logic                     neg_a, neg_b, neg_c;
  rmq_item_t                item_next;
  logic                     f_valid;
  rmq_item_t                f_item;

  assign r00 = in_data[15:0];
  assign r01 = in_data[31:16];
  assign r02 = in_data[47:32];
  assign r10 = in_data[63:48];
  assign r11 = in_data[79:64];
  assign r12 = in_data[95:80];
  assign r20 = in_data[111:96];
  assign r21 = in_data[127:112];
  assign r22 = in_data[143:128];

  always_comb begin
    diag_sum = 18'(r00) + 18'(r11) + 18'(r22);
    if (diag_sum > 0) begin
      path_sel = PATH_TRACE;
      t_full   = 19'(r00) + 19'(r11) + 19'(r22) + 19'(ONE_Q14);
    end else if (r00 > r11 && r00 > r22) begin
      path_sel = PATH_R00;
      t_full   = 19'(r00) - 19'(r11) - 19'(r22) + 19'(ONE_Q14);
    end else if (r11 > r22) begin
      path_sel = PATH_R11;
      t_full   = 19'(r11) - 19'(r00) - 19'(r22) + 19'(ONE_Q14);
    end else begin
      path_sel = PATH_R22;
      t_full   = 19'(r22) - 19'(r00) - 19'(r11) + 19'(ONE_Q14);
    end

    // Difference or sum of each off-diagonal pair, depending on the path.
    d_a = (path_sel == PATH_TRACE || path_sel == PATH_R22) ?
          18'(r01) - 18'(r10) : 18'(r01) + 18'(r10);
    d_b = (path_sel == PATH_TRACE || path_sel == PATH_R11) ?
          18'(r20) - 18'(r02) : 18'(r20) + 18'(r02);
    d_c = (path_sel == PATH_TRACE || path_sel == PATH_R00) ?
          18'(r12) - 18'(r21) : 18'(r12) + 18'(r21);
    neg_a = d_a[17];
    neg_b = d_b[17];
    neg_c = d_c[17];

    item_next.t     = (t_full < 19'sd1) ? T_W'(1) : t_full[T_W-1:0];
    item_next.path  = path_sel;
    item_next.neg   = {neg_c, neg_b, neg_a};
    item_next.mag_a = neg_a ? 17'(-d_a) : d_a[16:0];
    item_next.mag_b = neg_b ? 17'(-d_b) : d_b[16:0];
    item_next.mag_c = neg_c ? 17'(-d_c) : d_c[16:0];
  end

  assign in_ready = !f_valid || !q_full;
  assign q_push   = f_valid && !q_full;
  assign q_item   = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      f_item <= item_next;
    end
  end

endmodule

// ----- sv/rmq_queue.sv -----
// Small register queue between the classifier and the arithmetic pipeline.
module rmq_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rmq_pkg::rmq_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output rmq_pkg::rmq_item_t head
);
  import rmq_pkg::*;

  localparam int DEPTH = 4;

  rmq_item_t  slots [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  assign full  = (count == 3'(DEPTH));
  assign empty = (count == 3'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (push && !pop) begin
        count <= count + 3'd1;
      end else if (pop && !push) begin
        count <= count - 3'd1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- sv/rmq_div.sv -----
// Pipelined restoring divider: floor(sq * 2^14 / den), clamped at 2^32.
module rmq_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rmq_pkg::SQ_W-1:0]   sq,
  input  logic [rmq_pkg::T_W-1:0]    den,
  output logic [rmq_pkg::SQ_W-1:0]   quo
);
  import rmq_pkg::*;

  logic [T_W-1:0]       rem  [DIV_STEPS+1];
  logic [31:0]          low  [DIV_STEPS+1];
  logic [31:0]          qb   [DIV_STEPS+1];
  logic [T_W-1:0]       dv   [DIV_STEPS+1];
  logic                 sat  [DIV_STEPS+1];
  logic [T_W:0]         trial_rem [DIV_STEPS+1];
  logic                 ge   [DIV_STEPS+1];
  logic [T_W-1:0]       rem_next [DIV_STEPS+1];

  always_comb begin
    for (int k = 0; k <= DIV_STEPS; k++) begin
      trial_rem[k] = '0;
      ge[k]        = 1'b0;
      rem_next[k]  = '0;
    end
    for (int k = 1; k <= DIV_STEPS; k++) begin
      trial_rem[k] = {rem[k-1], low[k-1][31]};
      ge[k]        = trial_rem[k] >= {1'b0, dv[k-1]};
      rem_next[k]  = ge[k] ? T_W'(trial_rem[k] - {1'b0, dv[k-1]}) : trial_rem[k][T_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= T_W'(sq[SQ_W-1:18]);
      low[0] <= {sq[17:0], 14'd0};
      qb[0]  <= '0;
      dv[0]  <= den;
      sat[0] <= T_W'(sq[SQ_W-1:18]) >= den;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        rem[k] <= rem_next[k];
        low[k] <= {low[k-1][30:0], 1'b0};
        qb[k]  <= {qb[k-1][30:0], ge[k]};
        dv[k]  <= dv[k-1];
        sat[k] <= sat[k-1];
      end
    end
  end

  assign quo = sat[DIV_STEPS] ? {1'b1, 32'd0} : {1'b0, qb[DIV_STEPS]};

endmodule

// ----- sv/rmq_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module rmq_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rmq_pkg::RAD_W-1:0]   rad,
  output logic [rmq_pkg::ROOT_W-1:0]  root
);
  import rmq_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rm   [SQRT_LAT];
  logic [ROOT_W-1:0] rt   [SQRT_LAT];
  logic [RAD_W-1:0]  bl   [SQRT_LAT];
  logic [REM_W-1:0]  src_rem  [SQRT_LAT];
  logic [ROOT_W-1:0] src_root [SQRT_LAT];
  logic [RAD_W-1:0]  src_bits [SQRT_LAT];
  logic [REM_W+1:0]  shifted  [SQRT_LAT];
  logic [REM_W+1:0]  trial    [SQRT_LAT];
  logic              ge       [SQRT_LAT];

  always_comb begin
    for (int i = 0; i < SQRT_LAT; i++) begin
      src_rem[i]  = (i == 0) ? '0 : rm[(i == 0) ? 0 : i-1];
      src_root[i] = (i == 0) ? '0 : rt[(i == 0) ? 0 : i-1];
      src_bits[i] = (i == 0) ? rad : bl[(i == 0) ? 0 : i-1];
      shifted[i]  = {src_rem[i], src_bits[i][RAD_W-1:RAD_W-2]};
      trial[i]    = (REM_W+2)'({src_root[i], 2'b01});
      ge[i]       = shifted[i] >= trial[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SQRT_LAT; i++) begin
        rm[i] <= ge[i] ? REM_W'(shifted[i] - trial[i]) : REM_W'(shifted[i]);
        rt[i] <= {src_root[i][ROOT_W-2:0], ge[i]};
        bl[i] <= {src_bits[i][RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = rt[SQRT_LAT-1];

endmodule

// ----- sv/rmq_back.sv -----
// Arithmetic pipeline: squares, divides, takes roots, rounds and maps by path.
module rmq_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  rmq_pkg::rmq_item_t  q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         qw,
  output logic [15:0]         qx,
  output logic [15:0]         qy,
  output logic [15:0]         qz,
  output logic [1:0]          path_out
);
  import rmq_pkg::*;

  logic                adv;
  logic                s0_valid;
  logic [SQ_W-1:0]     s0_sq_a, s0_sq_b, s0_sq_c;
  logic [T_W-1:0]      s0_t;
  logic [RAD_W-1:0]    s0_piv;
  rmq_path_t           s0_path;
  logic [2:0]          s0_neg;
  logic                vld       [SIDE_LAT];
  rmq_path_t           side_path [SIDE_LAT];
  logic [2:0]          side_neg  [SIDE_LAT];
  logic [RAD_W-1:0]    piv_dly   [DIV_LAT];
  logic [SQ_W-1:0]     quo_a, quo_b, quo_c;
  logic [ROOT_W-1:0]   root_a, root_b, root_c, root_p;
  logic [15:0]         val_a, val_b, val_c, val_p;
  logic [15:0]         w_next, x_next, y_next, z_next;

  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      for (int k = 0; k < SIDE_LAT; k++) begin
        vld[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= q_pop;
      vld[0]   <= s0_valid;
      for (int k = 1; k < SIDE_LAT; k++) begin
        vld[k] <= vld[k-1];
      end
      out_valid <= vld[SIDE_LAT-1];
    end
    if (adv) begin
      s0_sq_a <= SQ_W'(q_head.mag_a) * SQ_W'(q_head.mag_a);
      s0_sq_b <= SQ_W'(q_head.mag_b) * SQ_W'(q_head.mag_b);
      s0_sq_c <= SQ_W'(q_head.mag_c) * SQ_W'(q_head.mag_c);
      s0_t    <= q_head.t;
      s0_piv  <= RAD_W'({q_head.t, 14'd0});
      s0_path <= q_head.path;
      s0_neg  <= q_head.neg;
      side_path[0] <= s0_path;
      side_neg[0]  <= s0_neg;
      piv_dly[0]   <= s0_piv;
      for (int k = 1; k < SIDE_LAT; k++) begin
        side_path[k] <= side_path[k-1];
        side_neg[k]  <= side_neg[k-1];
      end
      for (int k = 1; k < DIV_LAT; k++) begin
        piv_dly[k] <= piv_dly[k-1];
      end
      qw       <= w_next;
      qx       <= x_next;
      qy       <= y_next;
      qz       <= z_next;
      path_out <= side_path[SIDE_LAT-1];
    end
  end

  rmq_div u_div_a (.clk(clk), .en(adv), .sq(s0_sq_a), .den(s0_t), .quo(quo_a));
  rmq_div u_div_b (.clk(clk), .en(adv), .sq(s0_sq_b), .den(s0_t), .quo(quo_b));
  rmq_div u_div_c (.clk(clk), .en(adv), .sq(s0_sq_c), .den(s0_t), .quo(quo_c));

  rmq_isqrt u_sqrt_a (.clk(clk), .en(adv), .rad(RAD_W'(quo_a)), .root(root_a));
  rmq_isqrt u_sqrt_b (.clk(clk), .en(adv), .rad(RAD_W'(quo_b)), .root(root_b));
  rmq_isqrt u_sqrt_c (.clk(clk), .en(adv), .rad(RAD_W'(quo_c)), .root(root_c));
  rmq_isqrt u_sqrt_p (.clk(clk), .en(adv), .rad(piv_dly[DIV_LAT-1]), .root(root_p));

  // The root is twice the magnitude; halve it with round-half-up, then saturate.
  function automatic logic [15:0] finish(input logic [ROOT_W-1:0] r, input logic neg);
    logic [ROOT_W:0] half;
    half = ({1'b0, r} + (ROOT_W+1)'(1)) >> 1;
    if (neg) begin
      finish = (half >= (ROOT_W+1)'(32768)) ? 16'h8000 : 16'(-half);
    end else begin
      finish = (half >= (ROOT_W+1)'(32767)) ? 16'h7FFF : half[15:0];
    end
  endfunction

  always_comb begin
    val_a = finish(root_a, side_neg[SIDE_LAT-1][0]);
    val_b = finish(root_b, side_neg[SIDE_LAT-1][1]);
    val_c = finish(root_c, side_neg[SIDE_LAT-1][2]);
    val_p = finish(root_p, 1'b0);
    case (side_path[SIDE_LAT-1])
      PATH_TRACE: begin
        w_next = val_p; z_next = val_a; y_next = val_b; x_next = val_c;
      end
      PATH_R00: begin
        x_next = val_p; y_next = val_a; z_next = val_b; w_next = val_c;
      end
      PATH_R11: begin
        y_next = val_p; x_next = val_a; w_next = val_b; z_next = val_c;
      end
      default: begin
        z_next = val_p; w_next = val_a; x_next = val_b; y_next = val_c;
      end
    endcase
  end

endmodule

// ----- sv/rotation_matrix_to_quaternion_unit.sv -----
// Top level of the rotation-matrix-to-quaternion unit.
//
// This unit converts a 3x3 rotation matrix of signed Q2.14 elements into a
// quaternion (w, x, y, z) in signed Q2.14 using Shepperd's method, and reports
// which path was used (trace, or pivot on r00, r11 or r22). A classifier at
// the input picks the path, forms t and the three off-diagonal pair terms, and
// hands the item through a four-entry queue to a fully pipelined arithmetic
// back end: a squaring register, a 33-stage restoring divider and a 17-stage
// square root, then one output register. While the output side does not stall,
// a new matrix can be accepted every cycle. On its way to the output, each
// matrix passes the classifier register, the queue, the squaring register,
// the divider stages, the square-root stages and the output register. Every
// component is rounded to nearest with ties away from zero and saturated to
// 16 bits. When the output is stalled the whole pipeline holds, and the queue
// keeps absorbing input transfers until it fills.
module rotation_matrix_to_quaternion_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [143:0]  s_axis_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata,   // qw, qx, qy, qz
  output logic [1:0]    m_axis_tuser    // path_taken
);
  import rmq_pkg::*;

  rmq_item_t   front_item;
  rmq_item_t   head_item;
  logic        q_push, q_pop, q_full, q_empty;
  logic [15:0] qw, qx, qy, qz;

  rmq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (front_item)
  );

  rmq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (head_item)
  );

  rmq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (head_item),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .qw        (qw),
    .qx        (qx),
    .qy        (qy),
    .qz        (qz),
    .path_out  (m_axis_tuser)
  );

  assign m_axis_tdata = {qz, qy, qx, qw};

endmodule

// ----- tb/tb_rotation_matrix_to_quaternion_unit.sv -----
// Testbench for the rotation-matrix-to-quaternion unit: directed table plus random matrices.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion_unit;
  import rmq_pkg::*;

  // One quaternion result as it leaves the unit.
  typedef struct packed {
    rmq_path_t   path;
    logic [15:0] qw;
    logic [15:0] qx;
    logic [15:0] qy;
    logic [15:0] qz;
  } quat_t;

  // One row of the directed table. When has_quat is set, the typed-in quaternion
  // is compared against the predictor as well, so a typo in the table is caught.
  typedef struct {
    logic signed [15:0] m [9];
    logic               has_quat;
    quat_t              quat;
  } matrix_row_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  quat_t pending_quats [$];
  int    fail_count;
  bit    no_idle;       // Set for the final stretch of the run.
  bit    hold_output;   // Long receiver hold-off requested by the sender.

  rotation_matrix_to_quaternion_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  // Integer square root, floor, over 64 bits.
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // 0.5*sqrt(t) in Q2.14, rounded and clipped to the positive range.
  function automatic logic [15:0] half_root(longint unsigned t);
    longint unsigned mag;
    mag = (isqrt(t << 14) + 1) >> 1;
    if (mag > 32767) mag = 32767;
    return mag[15:0];
  endfunction

  // d/(2*sqrt(t)) in Q2.14, rounded half away from zero and saturated.
  function automatic logic [15:0] scaled_pair(longint d, longint unsigned t);
    longint unsigned a;
    longint unsigned mag;
    longint          v;
    a = ((d < 0) ? -d : d) * 64;
    mag = (isqrt((4 * a * a) / t) + 1) >> 1;
    if (d < 0) begin
      if (mag > 32768) mag = 32768;
      v = -longint'(mag);
    end else begin
      if (mag > 32767) mag = 32767;
      v = longint'(mag);
    end
    return v[15:0];
  endfunction

  // Shepperd path selection and the four components.
  function automatic quat_t predict_quaternion(logic signed [15:0] m [9]);
    longint e [9];
    longint tsum;
    longint unsigned t;
    quat_t q;
    for (int i = 0; i < 9; i++) e[i] = m[i];
    if (e[0] + e[4] + e[8] > 0) begin
      q.path = PATH_TRACE;
      tsum = e[0] + e[4] + e[8] + ONE_Q14;
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      q.path = PATH_R00;
      tsum = e[0] - e[4] - e[8] + ONE_Q14;
    end else if (e[4] > e[8]) begin
      q.path = PATH_R11;
      tsum = -e[0] + e[4] - e[8] + ONE_Q14;
    end else begin
      q.path = PATH_R22;
      tsum = -e[0] - e[4] + e[8] + ONE_Q14;
    end
    t = (tsum < 1) ? 1 : tsum;
    case (q.path)
      PATH_TRACE: begin
        q.qw = half_root(t);
        q.qz = scaled_pair(e[1] - e[3], t);
        q.qy = scaled_pair(e[6] - e[2], t);
        q.qx = scaled_pair(e[5] - e[7], t);
      end
      PATH_R00: begin
        q.qx = half_root(t);
        q.qy = scaled_pair(e[1] + e[3], t);
        q.qz = scaled_pair(e[6] + e[2], t);
        q.qw = scaled_pair(e[5] - e[7], t);
      end
      PATH_R11: begin
        q.qy = half_root(t);
        q.qx = scaled_pair(e[1] + e[3], t);
        q.qw = scaled_pair(e[6] - e[2], t);
        q.qz = scaled_pair(e[5] + e[7], t);
      end
      default: begin
        q.qz = half_root(t);
        q.qw = scaled_pair(e[1] - e[3], t);
        q.qx = scaled_pair(e[6] + e[2], t);
        q.qy = scaled_pair(e[5] + e[7], t);
      end
    endcase
    return q;
  endfunction

  // Offers one matrix and holds it until the transfer happens. The expectation
  // is queued at the accepting edge so it is in place before any result.
  task automatic send_matrix(logic signed [15:0] m [9], bit allow_idle);
    logic [143:0] bus;
    quat_t q;
    if (allow_idle && !no_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    for (int i = 0; i < 9; i++) bus[16*i +: 16] = m[i];
    q = predict_quaternion(m);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bus;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_quats.push_back(q);
  endtask

  // Random matrix: mostly elements within +/-1.0 with a chosen dominant
  // diagonal, some within +/-1.0 without one, the rest fully random raw bits.
  task automatic random_matrix(output logic signed [15:0] m [9]);
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (mode < 3) m[i] = $urandom;
      else m[i] = $signed($urandom_range(0, 32768)) - 16384;
    end
    if (mode >= 3 && mode <= 8) begin
      // Push one diagonal element up and the others down so every path is hit.
      case (mode % 4)
        0: begin
          m[0] = $urandom_range(8192, 16384); m[4] = m[0] - 100; m[8] = m[0] - 200;
        end
        1: begin
          m[0] = $urandom_range(0, 16384); m[4] = -m[0];
          m[8] = -$urandom_range(0, 16384);
        end
        2: begin
          m[4] = $urandom_range(0, 16384); m[0] = -m[4];
          m[8] = -$urandom_range(0, 16384);
        end
        default: begin
          m[8] = $urandom_range(0, 16384); m[0] = -m[8];
          m[4] = -$urandom_range(0, 16384);
        end
      endcase
    end
  endtask

  // Result side: compares each output transfer with the oldest expectation.
  always @(posedge clk) begin
    quat_t got;
    quat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.path = rmq_path_t'(m_axis_tuser);
      got.qw   = m_axis_tdata[15:0];
      got.qx   = m_axis_tdata[31:16];
      got.qy   = m_axis_tdata[47:32];
      got.qz   = m_axis_tdata[63:48];
      if (pending_quats.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, got);
        fail_count++;
      end else begin
        want = pending_quats.pop_front();
        if (got.path !== want.path) begin
          $display("%0t: path expected %0d actual %0d", $time, want.path, got.path);
          fail_count++;
        end
        if (got.qw !== want.qw) begin
          $display("%0t: qw expected %h actual %h", $time, want.qw, got.qw);
          fail_count++;
        end
        if (got.qx !== want.qx) begin
          $display("%0t: qx expected %h actual %h", $time, want.qx, got.qx);
          fail_count++;
        end
        if (got.qy !== want.qy) begin
          $display("%0t: qy expected %h actual %h", $time, want.qy, got.qy);
          fail_count++;
        end
        if (got.qz !== want.qz) begin
          $display("%0t: qz expected %h actual %h", $time, want.qz, got.qz);
          fail_count++;
        end
      end
    end
  end

  // Receiver readiness: random stall bursts, plus one long hold-off counted here.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_output) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_output = 0;
      end else if (!no_idle && $urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    matrix_row_t rows [$];
    matrix_row_t row;
    logic signed [15:0] m [9];
    int drain;
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    fail_count = 0;
    no_idle = 0;
    hold_output = 0;

    // Identity: trace path, w = 1.0 exactly.
    row.m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
    row.has_quat = 1;
    row.quat = '{PATH_TRACE, 16'h4000, 16'h0000, 16'h0000, 16'h0000};
    rows.push_back(row);
    // 180 degrees about x: pivot on r00, x = 1.0.
    row.m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
    row.quat = '{PATH_R00, 16'h0000, 16'h4000, 16'h0000, 16'h0000};
    rows.push_back(row);
    // 180 degrees about y: pivot on r11.
    row.m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
    row.quat = '{PATH_R11, 16'h0000, 16'h0000, 16'h4000, 16'h0000};
    rows.push_back(row);
    // 180 degrees about z: pivot on r22.
    row.m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
    row.quat = '{PATH_R22, 16'h0000, 16'h0000, 16'h0000, 16'h4000};
    rows.push_back(row);
    // All zeros: trace not positive, diagonal tie goes to r22, t = 1.0.
    row.m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    row.quat = '{PATH_R22, 16'h0000, 16'h0000, 16'h0000, 16'h2000};
    rows.push_back(row);
    row.has_quat = 0;
    // Ties between r00 and r11 go to r11.
    row.m = '{-100, 5, 6, 7, -100, 8, 9, 10, -300};
    rows.push_back(row);
    // Largest elements everywhere: trace path, pair terms all zero.
    row.m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    rows.push_back(row);
    // Most negative everywhere: non-positive trace, tie to r22.
    row.m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    rows.push_back(row);
    // Huge off-diagonal pairs of both signs, on the three pivot paths.
    row.m = '{-16384, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0};
    rows.push_back(row);
    row.m = '{1, -32768, 32767, 32767, 0, -32768, -32768, 32767, -1};
    rows.push_back(row);
    row.m = '{-32768, 32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768};
    rows.push_back(row);
    row.m = '{32767, -32768, -32768, -32768, -32768, 32767, 32767, 32767, -32768};
    rows.push_back(row);
    // Mixed-sign bit patterns so every data bit toggles.
    row.m = '{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
              16'sh5555, 16'shAAAA, 16'sh5555};
    rows.push_back(row);
    row.m = '{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
              16'shAAAA, 16'sh5555, 16'shAAAA};
    rows.push_back(row);
    // 90 degrees about z.
    row.m = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384};
    rows.push_back(row);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].has_quat && predict_quaternion(rows[i].m) !== rows[i].quat) begin
        $display("%0t: table row %0d expected %p actual %p", $time, i, rows[i].quat,
                 predict_quaternion(rows[i].m));
        fail_count++;
      end
      send_matrix(rows[i].m, 1);
    end

    // Sender pauses until every expected result has come.
    s_axis_tvalid <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk);

    // Long receiver hold-off while the sender keeps offering back to back.
    hold_output = 1;
    for (int n = 0; n < 120; n++) begin
      random_matrix(m);
      send_matrix(m, 0);
    end

    for (int n = 0; n < 560; n++) begin
      if (n == 460) no_idle = 1;
      random_matrix(m);
      send_matrix(m, 1);
    end
    s_axis_tvalid <= 1'b0;
    no_idle = 1;

    while (pending_quats.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 100) begin
      @(posedge clk);
      drain++;
    end
    if (fail_count == 0 && pending_quats.size() == 0) begin
      $display("tb_rotation_matrix_to_quaternion_unit: PASS");
    end else begin
      $display("tb_rotation_matrix_to_quaternion_unit: FAIL");
    end
    $finish;
  end

  // Watchdog: generous bound over the slowest correct run.
  initial begin
    #2000000;
    $display("tb_rotation_matrix_to_quaternion_unit: FAIL");
    $finish;
  end

endmodule

// ----- rotation_matrix_to_quaternion_unit.f -----
sv/rmq_pkg.sv
sv/rmq_front.sv
sv/rmq_queue.sv
sv/rmq_div.sv
sv/rmq_isqrt.sv
sv/rmq_back.sv
sv/rotation_matrix_to_quaternion_unit.sv
tb/tb_rotation_matrix_to_quaternion_unit.sv
